// ===== hdl/tzs_pkg.sv =====
// shared types and constants of the threshold zero suppressor
package tzs_pkg;

  localparam int SAMPLE_W  = 15;
  localparam int WORD_W    = 16;
  localparam int PRESC_W   = 16;
  localparam int RUN_W     = 15;
  localparam int SLOTS     = 3;
  localparam int SLOT_W    = 2;
  localparam int CFG_IDX_W = 2;

  // run is cut once it reaches this many samples
  localparam logic [RUN_W:0] MAX_RUN = 16'd32768;

  localparam logic [WORD_W-1:0] WORD_MAX = 16'hffff;
  localparam logic [WORD_W:0]   PAD_ADD  = 17'd7;
  localparam logic [WORD_W:0]   PAD_MASK = 17'h1fff8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW      = 2'd0,
    CFG_HIGH     = 2'd1,
    CFG_PRESCALE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] low;
    logic [SAMPLE_W-1:0] high;
    logic [PRESC_W-1:0]  prescale;
  } cfg_t;

  // result words of one item, count word (if any) is always the last one
  typedef struct packed {
    logic [SLOTS-1:0][WORD_W-1:0] word;
    logic [SLOT_W-1:0]            num;
    logic                         has_count;
  } bundle_t;

endpackage

// ===== hdl/tzs_core.sv =====
// input register, event state and per-item suppression logic
module tzs_core (
  input  logic                          clk,
  input  logic                          rst,
  input  tzs_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tzs_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                          in_last,
  output logic                          bundle_valid,
  output tzs_pkg::bundle_t              bundle,
  input  logic                          bundle_take
);
  import tzs_pkg::*;

  logic                  held;
  logic [SAMPLE_W-1:0]   sample;
  logic                  last;
  logic                  move;

  logic                  event_open;
  logic                  event_sel;
  logic [RUN_W-1:0]      run_length;
  logic [PRESC_W-1:0]    event_phase;
  logic [WORD_W-1:0]     words_written;

  logic                  event_open_next;
  logic                  event_sel_next;
  logic [RUN_W-1:0]      run_length_next;
  logic [PRESC_W-1:0]    event_phase_next;
  logic [WORD_W-1:0]     words_written_next;

  assign move         = held && bundle_take;
  assign in_ready     = !held || bundle_take;
  assign bundle_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (move) begin
      held <= 1'b0;
    end
    if (in_valid && in_ready) begin
      sample <= in_sample;
      last   <= in_last;
    end
  end

  always_comb begin
    logic                sel;
    logic [RUN_W-1:0]    run;
    logic [RUN_W:0]      run_inc;
    logic [WORD_W-1:0]   ww;
    logic [PRESC_W:0]    phase_inc;
    logic [SLOT_W-1:0]   n;
    logic [SLOT_W-1:0]   pay;
    logic [WORD_W:0]     ww_sum;
    logic [WORD_W-1:0]   ww_sat;
    logic [WORD_W:0]     pad;
    logic                outband;

    bundle           = '0;
    n                = '0;
    pay              = '0;
    event_phase_next = event_phase;
    phase_inc        = {1'b0, event_phase} + 17'd1;

    if (!event_open) begin
      sel = (event_phase == '0);
      // prescale of zero acts as one: the compare then always wraps
      event_phase_next = (phase_inc >= {1'b0, cfg.prescale}) ? '0 : phase_inc[PRESC_W-1:0];
      run = '0;
      ww  = '0;
    end else begin
      sel = event_sel;
      run = run_length;
      ww  = words_written;
    end

    run_inc = {1'b0, run} + 16'd1;
    outband = (sample < cfg.low) || (sample > cfg.high);

    if (sel) begin
      if (outband) begin
        if (run != '0) begin
          bundle.word[n] = {1'b1, run - 15'd1};
          n   = n + 2'd1;
          pay = pay + 2'd1;
        end
        bundle.word[n] = {1'b0, sample};
        n   = n + 2'd1;
        pay = pay + 2'd1;
        run = '0;
      end else if (run_inc >= MAX_RUN) begin
        // spacer for a full run carries run length minus one, i.e. the old count
        bundle.word[n] = {1'b1, run};
        n   = n + 2'd1;
        pay = pay + 2'd1;
        run = '0;
      end else begin
        run = run_inc[RUN_W-1:0];
      end
    end

    if (last && sel && run != '0) begin
      bundle.word[n] = {1'b1, run - 15'd1};
      n   = n + 2'd1;
      pay = pay + 2'd1;
      run = '0;
    end

    ww_sum = {1'b0, ww} + {15'd0, pay};
    ww_sat = ww_sum[WORD_W] ? WORD_MAX : ww_sum[WORD_W-1:0];
    pad    = ({1'b0, ww_sat} + PAD_ADD) & PAD_MASK;

    if (last) begin
      bundle.word[n]   = sel ? (pad[WORD_W] ? WORD_MAX : pad[WORD_W-1:0]) : '0;
      n                = n + 2'd1;
      bundle.has_count = 1'b1;
    end
    bundle.num = n;

    if (last) begin
      event_open_next    = 1'b0;
      event_sel_next     = 1'b0;
      run_length_next    = '0;
      words_written_next = '0;
    end else begin
      event_open_next    = 1'b1;
      event_sel_next     = sel;
      run_length_next    = run;
      words_written_next = ww_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_open    <= 1'b0;
      event_sel     <= 1'b0;
      run_length    <= '0;
      event_phase   <= '0;
      words_written <= '0;
    end else if (move) begin
      event_open    <= event_open_next;
      event_sel     <= event_sel_next;
      run_length    <= run_length_next;
      event_phase   <= event_phase_next;
      words_written <= words_written_next;
    end
  end

endmodule

// ===== hdl/tzs_out.sv =====
// result register that hands out the words of one item one per cycle while out_ready is high
module tzs_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        bundle_valid,
  input  tzs_pkg::bundle_t            bundle,
  output logic                        bundle_take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tzs_pkg::WORD_W-1:0]  out_word,
  output logic                        out_is_count,
  output logic                        out_final
);
  import tzs_pkg::*;

  logic [SLOTS-1:0][WORD_W-1:0] words;
  logic [SLOT_W-1:0]            remain;
  logic                         has_count;
  logic                         pop;

  assign out_valid    = (remain != '0);
  assign pop          = out_valid && out_ready;
  // free for a new item when empty or when the last word leaves now
  assign bundle_take  = (remain == '0) || (remain == 2'd1 && out_ready);
  assign out_word     = words[0];
  assign out_is_count = has_count && (remain == 2'd1);
  assign out_final    = out_is_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (bundle_valid && bundle_take) begin
      remain <= bundle.num;
    end else if (pop) begin
      remain <= remain - 2'd1;
    end
    if (bundle_valid && bundle_take) begin
      words     <= bundle.word;
      has_count <= bundle.has_count;
    end else if (pop) begin
      words <= {words[SLOTS-1], words[SLOTS-1:1]};
    end
  end

endmodule

// ===== hdl/threshold_zero_suppressor.sv =====
// top level of the threshold zero suppressor
//
// input stream: one 15-bit digitizer sample per item in s_axis_tdata, s_axis_tlast
// marks the last sample of an event window. output stream: 16-bit words in
// m_axis_tdata; a data word has bit 15 clear, a spacer has bit 15 set and the
// in-band run length minus one below it. the count word closes each event with
// m_axis_tuser and m_axis_tlast high; it holds the payload word count rounded up
// to a multiple of 8 (zero for events dropped by the prescaler).
// thresholds and prescale are written through cfg_we / cfg_index / cfg_data; the
// user must do so only while the block is idle, the block does not enforce it.
// an accepted item waits in the input register, then its words leave from the
// result register. throughput: an item gives zero to three words; the output
// register drains one word per cycle while m_axis_tready is high, and a new
// item is taken in the same cycle the last word of the previous one leaves.
// a plain sample gives at most two words, a sample on a window end three.
// reset clears the event state, the prescale phase and the registers to their
// defaults (low 0, high 32767, prescale 1). a stall on m_axis_tready holds the
// current word and, once the input register is full, drops s_axis_tready.
module threshold_zero_suppressor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tzs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tzs_pkg::WORD_W-1:0]        cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // [14:0] sample, [15] zero
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata,  // [15:0] word
  output logic                              m_axis_tuser,  // [0] is_count
  output logic                              m_axis_tlast
);
  import tzs_pkg::*;

  cfg_t    cfg;
  bundle_t bundle;
  logic    bundle_valid;
  logic    bundle_take;

  // configuration registers, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low      <= '0;
      cfg.high     <= 15'h7fff;
      cfg.prescale <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LOW:      cfg.low      <= cfg_data[SAMPLE_W-1:0];
        CFG_HIGH:     cfg.high     <= cfg_data[SAMPLE_W-1:0];
        CFG_PRESCALE: cfg.prescale <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register and suppression logic
  tzs_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_sample    (s_axis_tdata[SAMPLE_W-1:0]),
    .in_last      (s_axis_tlast),
    .bundle_valid (bundle_valid),
    .bundle       (bundle),
    .bundle_take  (bundle_take)
  );

  // result register, one word per cycle while m_axis_tready is high
  tzs_out u_out (
    .clk          (clk),
    .rst          (rst),
    .bundle_valid (bundle_valid),
    .bundle       (bundle),
    .bundle_take  (bundle_take),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_word     (m_axis_tdata),
    .out_is_count (m_axis_tuser),
    .out_final    (m_axis_tlast)
  );

endmodule

// ===== dv/tb_threshold_zero_suppressor.sv =====
// self-checking testbench for the threshold zero suppressor top level
`timescale 1ns / 100ps

module tb_threshold_zero_suppressor;

  import tzs_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;  // watchdog, well above the slowest legal run
  localparam int SETTLE       = 8;        // cycles for items that give no word
  localparam int HOLD_CYCLES  = 150;      // long receiver stall, fills the block
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 24;

  // one word leaving the block
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              is_count;
    logic              final_res;
  } out_word_t;

  // suppressor behavior and the words it still owes
  class tzs_scoreboard;
    logic [SAMPLE_W-1:0] low_thr;
    logic [SAMPLE_W-1:0] high_thr;
    logic [PRESC_W-1:0]  prescale;
    int                  run_len;
    int                  phase;
    int                  nwords;
    bit                  ev_open;
    bit                  ev_sel;
    out_word_t           expected_words[$];
    int                  fails;

    function new();
      low_thr  = '0;
      high_thr = '1;
      prescale = 1;
      run_len  = 0;
      phase    = 0;
      nwords   = 0;
      ev_open  = 0;
      ev_sel   = 0;
      fails    = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [WORD_W-1:0] val);
      case (idx)
        CFG_LOW:      low_thr  = val[SAMPLE_W-1:0];
        CFG_HIGH:     high_thr = val[SAMPLE_W-1:0];
        CFG_PRESCALE: prescale = val;
        default: ;
      endcase
    endfunction

    function void push_word(logic [WORD_W-1:0] w, bit cnt);
      out_word_t o;
      o.word      = w;
      o.is_count  = cnt;
      o.final_res = cnt;
      expected_words.insert(expected_words.size(), o);
    endfunction

    function void push_payload(logic [WORD_W-1:0] w);
      if (nwords < 65535) nwords++;
      push_word(w, 1'b0);
    endfunction

    // spacer carries the run length minus one under the top bit
    function void push_spacer();
      logic [WORD_W-1:0] w;
      w = 16'h8000 | (16'(run_len - 1) & 16'h7fff);
      push_payload(w);
      run_len = 0;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] smp, bit last);
      int ps;
      int cnt;
      if (!ev_open) begin
        // prescale of zero behaves as one; an out-of-range phase wraps to zero
        ps      = (prescale == 0) ? 1 : int'(prescale);
        ev_sel  = (phase == 0);
        phase   = (phase + 1 >= ps) ? 0 : phase + 1;
        ev_open = 1;
        run_len = 0;
        nwords  = 0;
      end
      if (ev_sel) begin
        if (smp < low_thr || smp > high_thr) begin
          if (run_len != 0) push_spacer();
          push_payload({1'b0, smp});
        end else begin
          run_len++;
          if (run_len >= int'(MAX_RUN)) push_spacer();
        end
      end
      if (last) begin
        cnt = 0;
        if (ev_sel) begin
          if (run_len != 0) push_spacer();
          cnt = (nwords + 7) & ~7;
          if (cnt > 65535) cnt = 65535;
        end
        push_word(cnt[WORD_W-1:0], 1'b1);
        ev_open = 0;
        ev_sel  = 0;
        run_len = 0;
        nwords  = 0;
      end
    endfunction

    function void check_word(logic [WORD_W-1:0] word, logic is_count, logic final_res);
      out_word_t e;
      if (expected_words.size() == 0) begin
        $error("unexpected word %h (is_count %b, final_res %b)", word, is_count, final_res);
        fails++;
        return;
      end
      e = expected_words.pop_front();
      if (word !== e.word) begin
        $error("word: expected %h, actual %h", e.word, word);
        fails++;
      end
      if (is_count !== e.is_count) begin
        $error("is_count: expected %b, actual %b", e.is_count, is_count);
        fails++;
      end
      if (final_res !== e.final_res) begin
        $error("final_res: expected %b, actual %b", e.final_res, final_res);
        fails++;
      end
    endfunction

    function void check_drained();
      if (expected_words.size() != 0) begin
        $error("%0d expected words never arrived", expected_words.size());
        fails++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata;  // [14:0] sample, [15] zero
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [15:0]          m_axis_tdata;  // [15:0] word
  logic                 m_axis_tuser;  // [0] is_count
  logic                 m_axis_tlast;

  tzs_scoreboard sb = new();
  bit gaps_on  = 1'b0;   // random idling on both sides
  bit hold_req = 1'b0;   // ask the receiver for one long stall
  int cycle_cnt = 0;

  threshold_zero_suppressor u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // watchdog
  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("CHECKS FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // output monitor, sees pre-edge values of the handshake
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // receiver: random stalls, one long hold on request
  initial begin
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && ($urandom_range(0, 3) == 0)) begin
        m_axis_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // offer one sample and wait for it to be taken; called and returns at a rising edge
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit last);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, smp};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_sample(smp, last);
  endtask

  // stop offering and let the block run dry
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all three registers back to back
  task automatic set_config(input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi,
                            input logic [PRESC_W-1:0] ps);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOW;
    cfg_data  <= {1'b0, lo};
    @(posedge clk);
    cfg_index <= CFG_HIGH;
    cfg_data  <= {1'b0, hi};
    @(posedge clk);
    cfg_index <= CFG_PRESCALE;
    cfg_data  <= ps;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_LOW, {1'b0, lo});
    sb.set_reg(CFG_HIGH, {1'b0, hi});
    sb.set_reg(CFG_PRESCALE, ps);
  endtask

  // random sample biased toward the band edges, the band itself and the extremes
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 7 && sb.low_thr <= sb.high_thr) begin
      return SAMPLE_W'($urandom_range(sb.low_thr, sb.high_thr));
    end
    if (r == 7 && sb.low_thr != 0) return sb.low_thr - 15'd1;
    if (r == 8 && sb.high_thr != '1) return sb.high_thr + 15'd1;
    return SAMPLE_W'($urandom_range(0, 32767));
  endfunction

  task automatic random_config();
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [PRESC_W-1:0]  ps;
    case ($urandom_range(0, 4))
      0: begin lo = '0; hi = '1; end
      1: begin
        lo = SAMPLE_W'($urandom_range(0, 32000));
        hi = lo + SAMPLE_W'($urandom_range(0, 700));
      end
      2: begin
        hi = SAMPLE_W'($urandom_range(0, 32000));
        lo = hi + SAMPLE_W'($urandom_range(1, 700));
      end
      3: begin lo = SAMPLE_W'($urandom_range(0, 32767)); hi = lo; end
      default: begin
        lo = SAMPLE_W'($urandom_range(0, 32767));
        hi = SAMPLE_W'($urandom_range(0, 32767));
      end
    endcase
    case ($urandom_range(0, 5))
      0: ps = 16'd0;
      1: ps = 16'd65535;
      2: ps = 16'd2;
      default: ps = PRESC_W'(1 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0));
    endcase
    set_config(lo, hi, ps);
  endtask

  initial begin
    int n;
    int len;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_LOW;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: the whole range is in band, so only spacers and count words
    send_sample(0, 0);
    send_sample(32767, 0);
    send_sample(5, 1);
    // window of one sample opens and closes the event
    send_sample(100, 1);
    wait_idle();

    // band 1000..2000, both edges, both neighbors, extremes as data
    set_config(1000, 2000, 1);
    send_sample(0, 0);
    send_sample(32767, 0);
    send_sample(1000, 0);
    send_sample(2000, 0);
    send_sample(999, 0);
    send_sample(2001, 0);
    send_sample(1500, 1);
    send_sample(3000, 1);
    wait_idle();

    // low above high with prescale zero: everything passes as data
    set_config(32767, 0, 0);
    send_sample(0, 0);
    send_sample(16384, 0);
    send_sample(32767, 1);
    wait_idle();

    // one in three, then prescale lowered to the current phase
    set_config(0, 32767, 3);
    send_sample(7, 1);
    send_sample(7, 0);
    send_sample(8, 1);
    wait_idle();
    set_config(0, 32767, 2);
    send_sample(9, 1);
    send_sample(10, 1);
    wait_idle();

    // largest prescale
    set_config(0, 32767, 65535);
    send_sample(1, 1);
    send_sample(2, 1);
    wait_idle();

    // phase was left out of range, this event is dropped
    set_config(0, 32767, 1);
    send_sample(0, 1);
    wait_idle();

    // random phases; the first one without idling, a long receiver hold in the third
    for (int p = 0; p < RAND_PHASES; p++) begin
      random_config();
      gaps_on = (p != 0);
      if (p == 2) hold_req = 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
        for (int i = 0; i < len; i++) begin
          send_sample(pick_sample(), i == len - 1);
        end
        n += len;
      end
      wait_idle();
    end

    repeat (4 * SETTLE) @(posedge clk);
    sb.check_drained();
    if (sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
